>>> rtl/core/ccs_pkg.sv
// shared constants for the climate control step unit
// register map, field widths, reset values and coefficient defaults
// no dependencies
package ccs_pkg;

  // fixed-point fraction bits of the controller coefficients
  localparam int unsigned COEF_FRAC_BITS_DEF = 14;

  // apb register map
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_TEMP_SP  = 3'd0,
    REG_HUM_SP   = 3'd1,
    REG_CO2_SP   = 3'd2,
    REG_HUM_BAND = 3'd3,
    REG_CO2_BAND = 3'd4
  } reg_index_t;

  // register widths
  localparam int unsigned TEMP_SP_W  = 8;
  localparam int unsigned HUM_SP_W   = 7;
  localparam int unsigned CO2_SP_W   = 14;
  localparam int unsigned HUM_BAND_W = 6;
  localparam int unsigned CO2_BAND_W = 12;

  // register reset values
  localparam logic [TEMP_SP_W-1:0]  TEMP_SP_RST  = 8'd70;
  localparam logic [HUM_SP_W-1:0]   HUM_SP_RST   = 7'd50;
  localparam logic [CO2_SP_W-1:0]   CO2_SP_RST   = 14'd400;
  localparam logic [HUM_BAND_W-1:0] HUM_BAND_RST = 6'd3;
  localparam logic [CO2_BAND_W-1:0] CO2_BAND_RST = 12'd100;

  // field widths
  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned HUM_W   = 15;
  localparam int unsigned CO2_W   = 22;
  localparam int unsigned MASK_W  = 3;
  localparam int unsigned DRIVE_W = 7;

  // setpoint error stays within -127..383, so ten signed bits hold it
  localparam int unsigned ERR_W = 10;

  // drive snapping thresholds
  localparam int unsigned DRIVE_HIGH = 80;
  localparam int unsigned DRIVE_LOW  = 20;
  localparam logic [DRIVE_W-1:0] DRIVE_FULL = 7'd100;
  localparam logic [DRIVE_W-1:0] DRIVE_OFF  = 7'd0;

  // coefficients in thousandths
  localparam longint COEF_E2_MILLI = 974;
  localparam longint COEF_D1_MILLI = 1904;
  localparam longint COEF_D2_MILLI = 904;

  // run mask bits
  localparam int unsigned RUN_TEMP = 0;
  localparam int unsigned RUN_HUM  = 1;
  localparam int unsigned RUN_CO2  = 2;

endpackage

>>> rtl/core/climate_control_step_unit.sv
// climate control step unit: temperature difference-equation loop with drive
// snapping, humidity and co2 on/off loops with hysteresis, apb register port
// depends on ccs_pkg
//
// latency: a result is available the cycle after its tick is accepted
// throughput: one tick per cycle while out_ready is high; the drive recurrence is a
//   multiply-add sum over the held state, computed ahead of the state registers
// reset (rst, synchronous): registers to defaults, loop history and switches
//   cleared, no result pending
module climate_control_step_unit #(
  parameter int unsigned COEF_FRAC_BITS = ccs_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // apb configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ccs_pkg::PADDR_W-1:0]        paddr,
  input  logic [ccs_pkg::PDATA_W-1:0]        pwdata,
  output logic [ccs_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready,
  // tick channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [ccs_pkg::TEMP_W-1:0]  temperature,
  input  logic [ccs_pkg::HUM_W-1:0]          humidity,
  input  logic [ccs_pkg::CO2_W-1:0]          co2_level,
  input  logic [ccs_pkg::MASK_W-1:0]         run_mask,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ccs_pkg::DRIVE_W-1:0]        heat_level,
  output logic                               humidifier_on,
  output logic                               solenoid_on
);

  // accumulator is wide enough for the largest weighted sum of history
  localparam int unsigned ACC_W = COEF_FRAC_BITS + 12;
  localparam longint CoefOne = longint'(1) << COEF_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] COEF_E2 =
    ACC_W'((ccs_pkg::COEF_E2_MILLI * CoefOne + 500) / 1000);
  localparam logic signed [ACC_W-1:0] COEF_D1 =
    ACC_W'((ccs_pkg::COEF_D1_MILLI * CoefOne + 500) / 1000);
  localparam logic signed [ACC_W-1:0] COEF_D2 =
    ACC_W'((ccs_pkg::COEF_D2_MILLI * CoefOne + 500) / 1000);

  localparam int unsigned DIFF_W = ccs_pkg::TEMP_W + 2;
  localparam int unsigned HCMP_W = 18;
  localparam int unsigned CCMP_W = 24;

  // configuration registers
  logic [ccs_pkg::TEMP_SP_W-1:0]  temp_sp;
  logic [ccs_pkg::HUM_SP_W-1:0]   hum_sp;
  logic [ccs_pkg::CO2_SP_W-1:0]   co2_sp;
  logic [ccs_pkg::HUM_BAND_W-1:0] hum_band;
  logic [ccs_pkg::CO2_BAND_W-1:0] co2_band;

  // loop state; drive and switch states double as the result register
  logic signed [ccs_pkg::ERR_W-1:0] last_error;
  logic signed [ccs_pkg::ERR_W-1:0] error_before;
  logic [ccs_pkg::DRIVE_W-1:0]      last_drive;
  logic [ccs_pkg::DRIVE_W-1:0]      drive_before;
  logic                             humidifier_state;
  logic                             solenoid_state;

  logic                             in_fire;
  logic                             cfg_write;
  ccs_pkg::reg_index_t              reg_index;

  logic signed [DIFF_W-1:0]         diff;
  logic signed [DIFF_W-1:0]         diff_q;
  logic signed [ccs_pkg::ERR_W-1:0] error_next;

  logic signed [ACC_W-1:0]          acc;
  logic signed [ACC_W-1:0]          acc_q;
  logic [ccs_pkg::DRIVE_W-1:0]      drive_next;

  logic signed [HCMP_W-1:0]         hum_low;
  logic signed [HCMP_W-1:0]         hum_high;
  logic signed [HCMP_W-1:0]         hum_read;
  logic                             humidifier_next;

  logic signed [CCMP_W-1:0]         co2_low;
  logic signed [CCMP_W-1:0]         co2_high;
  logic signed [CCMP_W-1:0]         co2_read;
  logic                             solenoid_next;

  // handshakes: a new tick enters as soon as the pending result is taken
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = ccs_pkg::reg_index_t'(paddr[ccs_pkg::PADDR_W-1:2]);

  // register read-back
  always_comb begin
    prdata = '0;
    unique case (reg_index)
      ccs_pkg::REG_TEMP_SP:  prdata = ccs_pkg::PDATA_W'(temp_sp);
      ccs_pkg::REG_HUM_SP:   prdata = ccs_pkg::PDATA_W'(hum_sp);
      ccs_pkg::REG_CO2_SP:   prdata = ccs_pkg::PDATA_W'(co2_sp);
      ccs_pkg::REG_HUM_BAND: prdata = ccs_pkg::PDATA_W'(hum_band);
      ccs_pkg::REG_CO2_BAND: prdata = ccs_pkg::PDATA_W'(co2_band);
      default:               prdata = '0;
    endcase
  end

  // setpoint error, truncated toward zero
  always_comb begin
    diff       = $signed({2'b00, temp_sp, 8'h00}) - DIFF_W'(temperature);
    diff_q     = (diff >>> 8) + $signed(DIFF_W'(diff[DIFF_W-1] && (|diff[7:0])));
    error_next = diff_q[ccs_pkg::ERR_W-1:0];
  end

  // difference equation over the held history, then drive snapping
  always_comb begin
    acc = (ACC_W'(last_error) <<< COEF_FRAC_BITS)
        - COEF_E2 * ACC_W'(error_before)
        + COEF_D1 * $signed(ACC_W'(last_drive))
        - COEF_D2 * $signed(ACC_W'(drive_before));
    acc_q = (acc >>> COEF_FRAC_BITS)
          + $signed(ACC_W'(acc[ACC_W-1] && (|acc[COEF_FRAC_BITS-1:0])));
    priority if (acc_q >= $signed(ACC_W'(ccs_pkg::DRIVE_HIGH))) begin
      drive_next = ccs_pkg::DRIVE_FULL;
    end else if (acc_q <= $signed(ACC_W'(ccs_pkg::DRIVE_LOW))) begin
      drive_next = ccs_pkg::DRIVE_OFF;
    end else begin
      drive_next = acc_q[ccs_pkg::DRIVE_W-1:0];
    end
  end

  // humidity hysteresis, thresholds scaled to the reading's fraction bits
  always_comb begin
    hum_low  = (HCMP_W'(hum_sp) - HCMP_W'(hum_band)) <<< 8;
    hum_high = (HCMP_W'(hum_sp) + HCMP_W'(hum_band)) <<< 8;
    hum_read = HCMP_W'(humidity);
    priority if (hum_read <= hum_low) begin
      humidifier_next = 1'b1;
    end else if (hum_read >= hum_high) begin
      humidifier_next = 1'b0;
    end else begin
      humidifier_next = humidifier_state;
    end
  end

  // co2 hysteresis
  always_comb begin
    co2_low  = (CCMP_W'(co2_sp) - CCMP_W'(co2_band)) <<< 8;
    co2_high = (CCMP_W'(co2_sp) + CCMP_W'(co2_band)) <<< 8;
    co2_read = CCMP_W'(co2_level);
    priority if (co2_read <= co2_low) begin
      solenoid_next = 1'b1;
    end else if (co2_read >= co2_high) begin
      solenoid_next = 1'b0;
    end else begin
      solenoid_next = solenoid_state;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_sp  <= ccs_pkg::TEMP_SP_RST;
      hum_sp   <= ccs_pkg::HUM_SP_RST;
      co2_sp   <= ccs_pkg::CO2_SP_RST;
      hum_band <= ccs_pkg::HUM_BAND_RST;
      co2_band <= ccs_pkg::CO2_BAND_RST;
    end else if (cfg_write) begin
      unique case (reg_index)
        ccs_pkg::REG_TEMP_SP:  temp_sp  <= pwdata[ccs_pkg::TEMP_SP_W-1:0];
        ccs_pkg::REG_HUM_SP:   hum_sp   <= pwdata[ccs_pkg::HUM_SP_W-1:0];
        ccs_pkg::REG_CO2_SP:   co2_sp   <= pwdata[ccs_pkg::CO2_SP_W-1:0];
        ccs_pkg::REG_HUM_BAND: hum_band <= pwdata[ccs_pkg::HUM_BAND_W-1:0];
        ccs_pkg::REG_CO2_BAND: co2_band <= pwdata[ccs_pkg::CO2_BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // loop state and result valid; loops not due hold their state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error       <= '0;
      error_before     <= '0;
      last_drive       <= '0;
      drive_before     <= '0;
      humidifier_state <= 1'b0;
      solenoid_state   <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (in_fire) begin
        if (run_mask[ccs_pkg::RUN_TEMP]) begin
          error_before <= last_error;
          last_error   <= error_next;
          drive_before <= last_drive;
          last_drive   <= drive_next;
        end
        if (run_mask[ccs_pkg::RUN_HUM]) begin
          humidifier_state <= humidifier_next;
        end
        if (run_mask[ccs_pkg::RUN_CO2]) begin
          solenoid_state <= solenoid_next;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result transaction fields
  assign heat_level    = last_drive;
  assign humidifier_on = humidifier_state;
  assign solenoid_on   = solenoid_state;

endmodule
